// ===== design/stu_pkg.sv =====
package stu_pkg;

  // Fixed payload widths
  localparam int unsigned WordBits   = 32;
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned BaseBits   = 6;
  localparam int unsigned CharBits   = 8;

  // Configuration port: byte address bits and register index field
  localparam int unsigned CfgAddrBits  = 3;
  localparam int unsigned CfgDataBits  = 32;
  localparam logic        RegBaseSelect = 1'b0;

  // Base codes
  localparam logic [BaseBits-1:0] BaseAuto = 6'd0;
  localparam logic [BaseBits-1:0] BaseBad  = 6'd1;
  localparam logic [BaseBits-1:0] BaseOct  = 6'd8;
  localparam logic [BaseBits-1:0] BaseDec  = 6'd10;
  localparam logic [BaseBits-1:0] BaseHex  = 6'd16;
  localparam logic [BaseBits-1:0] BaseMax  = 6'd36;

  // Character codes
  localparam logic [CharBits-1:0] ChTab   = 8'h09;
  localparam logic [CharBits-1:0] ChCr    = 8'h0d;
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChPlus  = 8'h2b;
  localparam logic [CharBits-1:0] ChMinus = 8'h2d;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;
  localparam logic [CharBits-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharBits-1:0] ChLowA  = 8'h61;
  localparam logic [CharBits-1:0] ChLowX  = 8'h78;
  localparam logic [CharBits-1:0] ChLowZ  = 8'h7a;
  // Letter digits start at ten
  localparam logic [CharBits-1:0] UpOffset  = 8'd55;
  localparam logic [CharBits-1:0] LowOffset = 8'd87;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusRange   = 2'd1,
    StatusBadBase = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    PhWs     = 7'b0000001,
    PhStart  = 7'b0000010,
    PhZero   = 7'b0000100,
    PhAfterx = 7'b0001000,
    PhDigits = 7'b0010000,
    PhDone   = 7'b0100000,
    PhBad    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                last_char;
  } in_beat_t;

  typedef struct packed {
    logic [WordBits-1:0]   value;
    logic [OffsetBits-1:0] end_offset;
    status_e               status;
    logic                  digits_seen;
  } out_beat_t;

  typedef struct packed {
    logic                digit_ok;
    logic                overflow;
    logic [WordBits-1:0] acc_next;
  } digit_res_t;

endpackage

// ===== design/string_to_unsigned_parser.sv =====
// Takes one character beat per cycle; a new beat is accepted every cycle unless an untaken result holds in_ready_o low.
// The result is registered: it appears on out_valid_o in the cycle after the last_char beat is accepted.
// Each character goes through the single multiply-add by the base.
// Reset: asynchronous, active low; clears parse state, base_select and the output
// valid. The base is latched on the first character of each string.
module string_to_unsigned_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  stu_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output stu_pkg::out_beat_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stu_pkg::CfgAddrBits-1:0] paddr,
  input  logic [stu_pkg::CfgDataBits-1:0] pwdata,
  output logic [stu_pkg::CfgDataBits-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned WB = stu_pkg::WordBits;
  localparam int unsigned OB = stu_pkg::OffsetBits;
  localparam int unsigned BB = stu_pkg::BaseBits;

  logic [BB-1:0]       base_select_q, base_select_d;
  stu_pkg::phase_e     phase_q, phase_d;
  logic [WB-1:0]       accum_q, accum_d;
  logic                minus_q, minus_d;
  logic [BB-1:0]       active_base_q, active_base_d;
  logic                any_digit_q, any_digit_d;
  logic [OB-1:0]       position_q, position_d;
  logic [OB-1:0]       stop_q, stop_d;
  logic                range_q, range_d;
  logic                out_valid_q, out_valid_d;
  stu_pkg::out_beat_t  out_q, out_d;

  logic                in_fire;
  logic                cfg_write;
  logic                first;
  logic [BB-1:0]       base_eff;
  logic [BB-1:0]       dig_base;
  logic                bad_base;
  stu_pkg::phase_e     phase_eff;
  logic [OB-1:0]       pos_next;
  logic                is_ws;
  logic                is_x;
  logic                take_start;
  logic                take_digit;
  logic                take_zero;
  logic                bad_end;
  logic [7:0]          ch;
  stu_pkg::digit_res_t dres;

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == stu_pkg::RegBaseSelect);
  assign base_select_d = cfg_write ? pwdata[BB-1:0] : base_select_q;
  assign prdata = (paddr[2] == stu_pkg::RegBaseSelect) ?
                  {{(stu_pkg::CfgDataBits-BB){1'b0}}, base_select_q} : '0;

  // Latch the base on the first character of a string
  assign ch        = in_data_i.character;
  assign first     = (position_q == '0);
  assign base_eff  = first ? base_select_q : active_base_q;
  assign bad_base  = (base_eff == stu_pkg::BaseBad) || (base_eff > stu_pkg::BaseMax);
  assign phase_eff = first ? (bad_base ? stu_pkg::PhBad : stu_pkg::PhWs) : phase_q;
  assign dig_base  = (base_eff == stu_pkg::BaseAuto) ? stu_pkg::BaseDec : base_eff;
  assign pos_next  = (position_q == '1) ? position_q : position_q + OB'(1);
  assign is_ws     = (ch == stu_pkg::ChSpace) || ((ch >= stu_pkg::ChTab) && (ch <= stu_pkg::ChCr));
  assign is_x      = (ch == stu_pkg::ChLowX) || (ch == stu_pkg::ChUpX);

  stu_digit_unit u_digit (
    .char_i (ch),
    .base_i (dig_base),
    .acc_i  (accum_q),
    .res_o  (dres)
  );

  // Advance the parse by one character
  always_comb begin
    phase_d       = phase_eff;
    accum_d       = accum_q;
    minus_d       = minus_q;
    active_base_d = base_eff;
    any_digit_d   = any_digit_q;
    stop_d        = stop_q;
    range_d       = range_q;
    take_start    = 1'b0;
    take_digit    = 1'b0;
    take_zero     = 1'b0;

    unique case (phase_eff)
      stu_pkg::PhWs: begin
        if (is_ws) begin
          phase_d = stu_pkg::PhWs;
        end else if (ch == stu_pkg::ChMinus) begin
          minus_d = 1'b1;
          phase_d = stu_pkg::PhStart;
        end else if (ch == stu_pkg::ChPlus) begin
          phase_d = stu_pkg::PhStart;
        end else begin
          take_start = 1'b1;
        end
      end
      stu_pkg::PhStart: begin
        take_start = 1'b1;
      end
      stu_pkg::PhZero: begin
        if (is_x) begin
          active_base_d = stu_pkg::BaseHex;
          phase_d       = stu_pkg::PhAfterx;
        end else begin
          take_digit = 1'b1;
        end
      end
      stu_pkg::PhAfterx, stu_pkg::PhDigits: begin
        take_digit = 1'b1;
      end
      default: begin
        phase_d = phase_eff;
      end
    endcase

    // Pick the base on the first significant character
    if (take_start) begin
      priority if (base_eff == stu_pkg::BaseAuto) begin
        if (ch == stu_pkg::ChZero) begin
          active_base_d = stu_pkg::BaseOct;
          take_zero     = 1'b1;
        end else begin
          active_base_d = stu_pkg::BaseDec;
          take_digit    = 1'b1;
        end
      end else if ((base_eff == stu_pkg::BaseHex) && (ch == stu_pkg::ChZero)) begin
        take_zero = 1'b1;
      end else begin
        take_digit = 1'b1;
      end
    end

    // Leading zero: may still turn into a hex prefix
    if (take_zero) begin
      any_digit_d = 1'b1;
      accum_d     = '0;
      stop_d      = pos_next;
      phase_d     = stu_pkg::PhZero;
    end

    // Accumulate a digit, or stop on a non-digit or carry out
    if (take_digit) begin
      if (!dres.digit_ok) begin
        phase_d = stu_pkg::PhDone;
      end else if (dres.overflow) begin
        any_digit_d = 1'b1;
        accum_d     = '1;
        minus_d     = 1'b0;
        range_d     = 1'b1;
        stop_d      = position_q;
        phase_d     = stu_pkg::PhDone;
      end else begin
        any_digit_d = 1'b1;
        accum_d     = dres.acc_next;
        stop_d      = pos_next;
        phase_d     = stu_pkg::PhDigits;
      end
    end
  end

  // Build the result beat from the updated state
  always_comb begin
    bad_end = (phase_d == stu_pkg::PhBad);
    out_d   = out_q;
    if (bad_end) begin
      out_d.value       = '0;
      out_d.end_offset  = '0;
      out_d.status      = stu_pkg::StatusBadBase;
      out_d.digits_seen = 1'b0;
    end else if (!any_digit_d) begin
      out_d.value       = '0;
      out_d.end_offset  = '0;
      out_d.status      = range_d ? stu_pkg::StatusRange : stu_pkg::StatusOk;
      out_d.digits_seen = 1'b0;
    end else begin
      out_d.value       = minus_d ? (~accum_d) + WB'(1) : accum_d;
      out_d.end_offset  = stop_d;
      out_d.status      = range_d ? stu_pkg::StatusRange : stu_pkg::StatusOk;
      out_d.digits_seen = 1'b1;
    end
  end

  // Output register: load on the last beat, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && in_data_i.last_char) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign position_d = pos_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_select_q <= stu_pkg::BaseAuto;
      out_valid_q   <= 1'b0;
    end else begin
      base_select_q <= base_select_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Parse state: update per beat, clear after the last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= stu_pkg::PhWs;
      accum_q       <= '0;
      minus_q       <= 1'b0;
      active_base_q <= stu_pkg::BaseAuto;
      any_digit_q   <= 1'b0;
      position_q    <= '0;
      stop_q        <= '0;
      range_q       <= 1'b0;
    end else if (in_fire) begin
      if (in_data_i.last_char) begin
        phase_q       <= stu_pkg::PhWs;
        accum_q       <= '0;
        minus_q       <= 1'b0;
        active_base_q <= stu_pkg::BaseAuto;
        any_digit_q   <= 1'b0;
        position_q    <= '0;
        stop_q        <= '0;
        range_q       <= 1'b0;
      end else begin
        phase_q       <= phase_d;
        accum_q       <= accum_d;
        minus_q       <= minus_d;
        active_base_q <= active_base_d;
        any_digit_q   <= any_digit_d;
        position_q    <= position_d;
        stop_q        <= stop_d;
        range_q       <= range_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_char) begin
      out_q <= out_d;
    end
  end

  // Checks
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parse phase not one-hot");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_char) |=> (position_q == '0) && !any_digit_q && out_valid_o)
    else $error("state not cleared after last beat");

  a_range_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_q |-> (accum_q == '1) && !minus_q && (phase_q == stu_pkg::PhDone))
    else $error("overflow did not saturate and stop");

  a_bad_base_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == stu_pkg::StatusBadBase)) |->
      (out_data_o.value == '0) && !out_data_o.digits_seen)
    else $error("bad base result not cleared");

  a_no_digit_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.digits_seen) |-> (out_data_o.end_offset == '0))
    else $error("offset set without digits");

endmodule

// ===== design/stu_digit_unit.sv =====
module stu_digit_unit (
  input  logic [stu_pkg::CharBits-1:0] char_i,
  input  logic [stu_pkg::BaseBits-1:0] base_i,
  input  logic [stu_pkg::WordBits-1:0] acc_i,
  output stu_pkg::digit_res_t          res_o
);

  localparam int unsigned ProdBits = stu_pkg::WordBits + stu_pkg::BaseBits;

  logic                         is_dec;
  logic                         is_up;
  logic                         is_low;
  logic [stu_pkg::CharBits-1:0] raw_digit;
  logic [stu_pkg::BaseBits-1:0] digit;
  logic [ProdBits-1:0]          prod;
  logic [ProdBits-1:0]          sum;

  // Decode the character into a digit value
  always_comb begin
    is_dec = (char_i >= stu_pkg::ChZero) && (char_i <= stu_pkg::ChNine);
    is_up  = (char_i >= stu_pkg::ChUpA) && (char_i <= stu_pkg::ChUpZ);
    is_low = (char_i >= stu_pkg::ChLowA) && (char_i <= stu_pkg::ChLowZ);
    priority if (is_dec) begin
      raw_digit = char_i - stu_pkg::ChZero;
    end else if (is_up) begin
      raw_digit = char_i - stu_pkg::UpOffset;
    end else begin
      raw_digit = char_i - stu_pkg::LowOffset;
    end
    digit = raw_digit[stu_pkg::BaseBits-1:0];
  end

  // Multiply-add by the base; any bit above the word means carry out
  assign prod = {{stu_pkg::BaseBits{1'b0}}, acc_i} * {{stu_pkg::WordBits{1'b0}}, base_i};
  assign sum  = prod + {{stu_pkg::WordBits{1'b0}}, digit};

  assign res_o.digit_ok = (is_dec || is_up || is_low) && (base_i >= 6'd2) && (digit < base_i);
  assign res_o.overflow = |sum[ProdBits-1:stu_pkg::WordBits];
  assign res_o.acc_next = sum[stu_pkg::WordBits-1:0];

endmodule
